/* design/vsss_pkg.sv */
// Package for the vehicle safety state sequencer: state and fan codes,
// node numbering, register indexes and the beat payload types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package vsss_pkg;

  // Width of the saturating per-node miss and mismatch counters.
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of the limit registers.
  localparam int unsigned LIMIT_W     = 16;
  // Width used when a counter is compared with a limit.
  localparam int unsigned CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int unsigned NUM_NODES   = 6;

  // Node positions in the masks, bit 0 is the central controller.
  localparam int unsigned N_CC  = 0;
  localparam int unsigned N_FSM = 1;
  localparam int unsigned N_RSM = 2;
  localparam int unsigned N_DIM = 3;
  localparam int unsigned N_AFC = 4;
  localparam int unsigned N_TM  = 5;

  localparam logic [LIMIT_W-1:0] HEARTBEAT_LIMIT_RST = LIMIT_W'(10);
  localparam logic [LIMIT_W-1:0] MISMATCH_LIMIT_RST  = LIMIT_W'(10);

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_GLV_ON  = 3'd1,
    ST_HV_EN   = 3'd2,
    ST_RTD     = 3'd3,
    ST_ERROR   = 3'd4,
    ST_CLEAR   = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    FAN_OFF  = 2'd0,
    FAN_LOW  = 2'd1,
    FAN_FULL = 2'd2,
    FAN_ERR  = 2'd3
  } fan_e;

  typedef enum logic [0:0] {
    REG_HEARTBEAT_LIMIT = 1'b0,
    REG_MISMATCH_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] cc_state;
    logic [2:0] fsm_state;
    logic [2:0] rsm_state;
    logic [2:0] dim_state;
    logic [2:0] afc_state;
    logic [2:0] tm_state;
    logic [5:0] heard_mask;
    logic [1:0] fan1_status;
    logic [1:0] fan2_status;
    logic [1:0] fan3_status;
    logic [2:0] requested_state;
  } tick_t;

  typedef struct packed {
    logic [2:0] system_state;
    logic [2:0] goal_state;
    logic [5:0] timeout_mask;
    logic [5:0] wrong_state_mask;
  } result_t;

  typedef struct packed {
    cfg_reg_e           index;
    logic [LIMIT_W-1:0] data;
  } cfg_t;

endpackage

`default_nettype wire

/* design/vsss_in_if.sv */
// Handshake channel carrying one tick beat into the sequencer.
// Depends on vsss_pkg for the payload type.
`default_nettype none

interface vsss_in_if;
  logic            valid;
  logic            ready;
  vsss_pkg::tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/vsss_out_if.sv */
// Handshake channel carrying one result beat out of the sequencer.
// Depends on vsss_pkg for the payload type.
`default_nettype none

interface vsss_out_if;
  logic              valid;
  logic              ready;
  vsss_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/vsss_cfg_if.sv */
// Register write channel of the sequencer: register index and data.
// Depends on vsss_pkg for the payload type.
`default_nettype none

interface vsss_cfg_if;
  logic           valid;
  logic           ready;
  vsss_pkg::cfg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/vehicle_safety_state_sequencer.sv */
// Vehicle safety state sequencer: goal arbitration, system state machine
// and per-node heartbeat and state monitor. Depends on vsss_pkg and the
// three channel interfaces.
//
//   Channel  Dir  Payload                     Beat
//   in_i     in   tick_t (node states, fans)  one tick
//   out_o    out  result_t (states, masks)    one result per tick
//   cfg_i    in   cfg_t (index, data)         one register write
//
// A tick beat is registered on entry and processed once the result register is
// free, when the state, counters and flags update and the result register loads.
// Throughput is one tick per cycle while the result side keeps taking results.
// The input stage keeps taking beats while a result waits, until both stages are full.
// Reset puts the system state in glv_on, clears counters and flags and
// loads both limits with ten. Register writes are always taken at once.
`default_nettype none

module vehicle_safety_state_sequencer (
  input  wire  clk_i,
  input  wire  rst_ni,
  vsss_in_if.sink    in_i,
  vsss_out_if.source out_o,
  vsss_cfg_if.sink   cfg_i
);
  import vsss_pkg::*;

  // Input stage.
  logic  in_vld_q;
  tick_t in_q;
  // Result stage.
  logic    out_vld_q;
  result_t out_q;
  // Sequencer and monitor state.
  state_e                 sys_q, sys_d;
  logic [LIMIT_W-1:0]     hb_lim_q, mm_lim_q;
  logic [COUNT_WIDTH-1:0] miss_q [NUM_NODES];
  logic [COUNT_WIDTH-1:0] miss_d [NUM_NODES];
  logic [COUNT_WIDTH-1:0] mism_q [NUM_NODES];
  logic [COUNT_WIDTH-1:0] mism_d [NUM_NODES];
  logic [NUM_NODES-1:0]   to_q, to_d, wr_q, wr_d;

  logic       adv;
  logic [2:0] ns [NUM_NODES];
  state_e     goal;
  logic       req_ok, near, crit_to, any_err, pre_err, match_cur;
  logic       fans_low, fans_high, fan_err;

  // The tick in the input stage is processed when the result register is free.
  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;
  assign cfg_i.ready = 1'b1;

  // Input stage valid and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_lim_q <= HEARTBEAT_LIMIT_RST;
      mm_lim_q <= MISMATCH_LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_HEARTBEAT_LIMIT: hb_lim_q <= cfg_i.payload.data;
        REG_MISMATCH_LIMIT:  mm_lim_q <= cfg_i.payload.data;
        default:             hb_lim_q <= hb_lim_q;
      endcase
    end
  end

  // Node states in mask order.
  always_comb begin
    ns[N_CC]  = in_q.cc_state;
    ns[N_FSM] = in_q.fsm_state;
    ns[N_RSM] = in_q.rsm_state;
    ns[N_DIM] = in_q.dim_state;
    ns[N_AFC] = in_q.afc_state;
    ns[N_TM]  = in_q.tm_state;
  end

  // Goal arbitration: a step of at most one without a DIM timeout, or a return
  // to glv_on from error or clearing; anything else keeps the current state as goal.
  always_comb begin
    near = (4'(in_q.requested_state) == 4'(sys_q)) ||
           (4'(in_q.requested_state) == 4'(sys_q) + 4'd1) ||
           (4'(sys_q) == 4'(in_q.requested_state) + 4'd1);
    req_ok = (in_q.requested_state <= ST_CLEAR) &&
             ((!to_q[N_DIM] && near) ||
              (in_q.requested_state == ST_GLV_ON &&
               (sys_q == ST_ERROR || sys_q == ST_CLEAR)));
    goal = req_ok ? state_e'(in_q.requested_state) : sys_q;
  end

  // Guard terms shared by the state machine.
  always_comb begin
    crit_to = to_q[N_AFC] || to_q[N_FSM] || to_q[N_DIM] || to_q[N_CC];
    any_err = ns[N_AFC] == ST_ERROR || ns[N_FSM] == ST_ERROR ||
              ns[N_DIM] == ST_ERROR || ns[N_CC] == ST_ERROR;
    match_cur = ns[N_CC] == sys_q && ns[N_FSM] == sys_q && ns[N_AFC] == sys_q;
    fans_low  = in_q.fan1_status == FAN_LOW && in_q.fan2_status == FAN_LOW &&
                in_q.fan3_status == FAN_LOW;
    fans_high = in_q.fan1_status == FAN_FULL && in_q.fan2_status == FAN_FULL &&
                in_q.fan3_status == FAN_FULL;
    fan_err   = in_q.fan1_status == FAN_ERR || in_q.fan2_status == FAN_ERR ||
                in_q.fan3_status == FAN_ERR;
    pre_err   = crit_to || (any_err && sys_q != ST_CLEAR);
  end

  // Next system state.
  always_comb begin
    sys_d = pre_err ? ST_ERROR : sys_q;
    unique case (sys_q)
      ST_GLV_ON: begin
        if (goal == ST_HV_EN && !pre_err && match_cur && fans_low) begin
          sys_d = ST_HV_EN;
        end
      end
      ST_HV_EN: begin
        if (fan_err) begin
          sys_d = ST_ERROR;
        end else if (goal == ST_GLV_ON && !pre_err) begin
          sys_d = ST_GLV_ON;
        end else if (goal == ST_RTD && !pre_err && match_cur && fans_high) begin
          sys_d = ST_RTD;
        end
      end
      ST_RTD: begin
        if (goal == ST_HV_EN && !pre_err && match_cur && fans_low) begin
          sys_d = ST_HV_EN;
        end
      end
      ST_ERROR, ST_UNKNOWN: begin
        if (goal == ST_GLV_ON && !crit_to && ns[N_CC] == ST_ERROR &&
            ns[N_FSM] == ST_ERROR && ns[N_AFC] == ST_ERROR && !fan_err) begin
          sys_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (goal == ST_GLV_ON && ns[N_CC] == ST_CLEAR && ns[N_FSM] == ST_CLEAR &&
            ns[N_DIM] == ST_CLEAR && ns[N_AFC] == ST_CLEAR) begin
          sys_d = ST_GLV_ON;
        end
      end
      default: sys_d = sys_q;
    endcase
  end

  // Per-node monitor: saturating counters that stop once their flag is set and clear
  // on a heartbeat or a match, mismatches measured against the new system state.
  always_comb begin
    for (int i = 0; i < NUM_NODES; i++) begin
      if (in_q.heard_mask[i]) begin
        miss_d[i] = '0;
      end else if (!to_q[i] && !(&miss_q[i])) begin
        miss_d[i] = miss_q[i] + COUNT_WIDTH'(1);
      end else begin
        miss_d[i] = miss_q[i];
      end

      if (ns[i] != sys_d) begin
        if (!wr_q[i] && !(&mism_q[i])) begin
          mism_d[i] = mism_q[i] + COUNT_WIDTH'(1);
        end else begin
          mism_d[i] = mism_q[i];
        end
      end else begin
        mism_d[i] = '0;
      end

      to_d[i] = CMP_W'(miss_d[i]) > CMP_W'(hb_lim_q);
      wr_d[i] = CMP_W'(mism_d[i]) > CMP_W'(mm_lim_q);
    end
  end

  // State register and monitor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q <= ST_GLV_ON;
      to_q  <= '0;
      wr_q  <= '0;
      for (int i = 0; i < NUM_NODES; i++) begin
        miss_q[i] <= '0;
        mism_q[i] <= '0;
      end
    end else if (adv) begin
      sys_q <= sys_d;
      to_q  <= to_d;
      wr_q  <= wr_d;
      for (int i = 0; i < NUM_NODES; i++) begin
        miss_q[i] <= miss_d[i];
        mism_q[i] <= mism_d[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.system_state     <= sys_d;
      out_q.goal_state       <= goal;
      out_q.timeout_mask     <= to_d;
      out_q.wrong_state_mask <= wr_d;
    end
  end

`ifndef SYNTHESIS
  // A processed tick leaves its new state and flags in the result register.
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_q.system_state == sys_q && out_q.timeout_mask == to_q &&
             out_q.wrong_state_mask == wr_q))
    else $error("result register does not match the updated state");

  // The state only moves when a tick is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sys_q))
    else $error("system state changed without a tick");

  // Input is refused only when both stages are full and the result is stalled.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // Entering hv_en from glv_on needs hv_en as accepted goal.
  a_hv_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && sys_q == ST_GLV_ON) |=> (sys_q != ST_HV_EN || out_q.goal_state == ST_HV_EN))
    else $error("hv_en entered without a matching goal");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the vehicle safety state sequencer: directed ticks, then
// random phases over several limit settings, with a tracking model checking every result.
// Depends on vsss_pkg, the three channel interfaces and the sequencer itself.
`timescale 1ns / 100ps

module testbench;
  import vsss_pkg::*;

  // Everything the sequencer remembers from one tick to the next.
  typedef struct packed {
    logic [2:0]                            sys;
    logic [2:0]                            goal;
    logic [NUM_NODES-1:0][COUNT_WIDTH-1:0] miss;
    logic [NUM_NODES-1:0][COUNT_WIDTH-1:0] mism;
    logic [NUM_NODES-1:0]                  timed_out;
    logic [NUM_NODES-1:0]                  wrong;
    logic [LIMIT_W-1:0]                    hb_limit;
    logic [LIMIT_W-1:0]                    mm_limit;
  } seq_model_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vsss_in_if  tick_ch ();
  vsss_out_if result_ch ();
  vsss_cfg_if cfg_ch ();

  vehicle_safety_state_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  // The planning copy runs ahead as ticks are queued; the tracking copy follows accepted beats.
  seq_model_t  planned_seq;
  seq_model_t  tracked_seq;
  tick_t       ticks_to_send[$];
  result_t     expected_results[$];
  int unsigned src_idle_pct  = 16;
  int unsigned sink_idle_pct = 45;
  logic        rx_hold       = 1'b0;
  logic        in_taken;
  int unsigned mismatches    = 0;
  int unsigned ticks_planned = 0;
  int unsigned ticks_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned state_hits[8];
  logic [5:0]  mute_mask     = '0;
  int unsigned mute_left     = 0;

  always #4 clk_i = ~clk_i;

  // One tick of the sequencer: goal arbitration, state step, then the node monitor.
  task automatic advance_sequencer(inout seq_model_t m, input tick_t t, output result_t r);
    logic [NUM_NODES-1:0][2:0] ns;
    logic [1:0] fan [3];
    logic [2:0] cur, req, goal, nxt;
    int         gap;
    logic       crit_to, any_err, trio_cur, fans_low, fans_high, fan_err;
    ns[N_CC]  = t.cc_state;
    ns[N_FSM] = t.fsm_state;
    ns[N_RSM] = t.rsm_state;
    ns[N_DIM] = t.dim_state;
    ns[N_AFC] = t.afc_state;
    ns[N_TM]  = t.tm_state;
    fan[0]    = t.fan1_status;
    fan[1]    = t.fan2_status;
    fan[2]    = t.fan3_status;
    req       = t.requested_state;
    cur       = m.sys;

    gap = int'(req) - int'(cur);
    if (gap < 0) gap = -gap;
    if (req <= ST_CLEAR && ((!m.timed_out[N_DIM] && gap <= 1) ||
        (req == ST_GLV_ON && (cur == ST_ERROR || cur == ST_CLEAR)))) goal = req;
    else goal = cur;

    fans_low  = fan[0] == FAN_LOW && fan[1] == FAN_LOW && fan[2] == FAN_LOW;
    fans_high = fan[0] == FAN_FULL && fan[1] == FAN_FULL && fan[2] == FAN_FULL;
    fan_err   = fan[0] == FAN_ERR || fan[1] == FAN_ERR || fan[2] == FAN_ERR;
    crit_to   = m.timed_out[N_AFC] || m.timed_out[N_FSM] || m.timed_out[N_DIM] ||
                m.timed_out[N_CC];
    any_err   = ns[N_AFC] == ST_ERROR || ns[N_FSM] == ST_ERROR || ns[N_DIM] == ST_ERROR ||
                ns[N_CC] == ST_ERROR;
    trio_cur  = ns[N_CC] == cur && ns[N_FSM] == cur && ns[N_AFC] == cur;

    nxt = cur;
    if (crit_to) nxt = ST_ERROR;
    if (any_err && cur != ST_CLEAR) nxt = ST_ERROR;

    case (cur)
      ST_GLV_ON: begin
        if (goal == ST_HV_EN && nxt != ST_ERROR && trio_cur && fans_low) nxt = ST_HV_EN;
      end
      ST_HV_EN: begin
        if (fan_err) nxt = ST_ERROR;
        else if (goal == ST_GLV_ON && nxt != ST_ERROR) nxt = ST_GLV_ON;
        else if (goal == ST_RTD && nxt != ST_ERROR && trio_cur && fans_high) nxt = ST_RTD;
      end
      ST_RTD: begin
        if (goal == ST_HV_EN && nxt != ST_ERROR && trio_cur && fans_low) nxt = ST_HV_EN;
      end
      ST_ERROR, ST_UNKNOWN: begin
        if (goal == ST_GLV_ON && !crit_to && ns[N_CC] == ST_ERROR && ns[N_FSM] == ST_ERROR &&
            ns[N_AFC] == ST_ERROR && !fan_err) nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (goal == ST_GLV_ON && ns[N_CC] == ST_CLEAR && ns[N_FSM] == ST_CLEAR &&
            ns[N_DIM] == ST_CLEAR && ns[N_AFC] == ST_CLEAR) nxt = ST_GLV_ON;
      end
      default: begin
      end
    endcase
    m.sys  = nxt;
    m.goal = goal;

    // Per-node heartbeat and state monitor, against the new system state.
    for (int i = 0; i < NUM_NODES; i++) begin
      if (t.heard_mask[i]) m.miss[i] = '0;
      else if (!m.timed_out[i] && m.miss[i] != '1) m.miss[i] = m.miss[i] + 1'b1;
      if (ns[i] != nxt) begin
        if (!m.wrong[i] && m.mism[i] != '1) m.mism[i] = m.mism[i] + 1'b1;
      end else begin
        m.mism[i] = '0;
      end
      m.timed_out[i] = m.miss[i] > m.hb_limit;
      m.wrong[i]     = m.mism[i] > m.mm_limit;
    end

    r.system_state     = m.sys;
    r.goal_state       = m.goal;
    r.timeout_mask     = m.timed_out;
    r.wrong_state_mask = m.wrong;
  endtask

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one result beat with the oldest outstanding prediction, field by field.
  task automatic check_result(input result_t got);
    result_t exp;
    if (expected_results.size() == 0) begin
      report_error($sformatf("result beat %h arrived with nothing outstanding", got));
    end else begin
      exp = expected_results.pop_front();
      results_seen++;
      state_hits[exp.system_state]++;
      if (got.system_state !== exp.system_state)
        report_error($sformatf("system_state expected %0d, got %0d",
                               exp.system_state, got.system_state));
      if (got.goal_state !== exp.goal_state)
        report_error($sformatf("goal_state expected %0d, got %0d",
                               exp.goal_state, got.goal_state));
      if (got.timeout_mask !== exp.timeout_mask)
        report_error($sformatf("timeout_mask expected %b, got %b",
                               exp.timeout_mask, got.timeout_mask));
      if (got.wrong_state_mask !== exp.wrong_state_mask)
        report_error($sformatf("wrong_state_mask expected %b, got %b",
                               exp.wrong_state_mask, got.wrong_state_mask));
    end
  endtask

  // Queue a tick and step the planning copy so later ticks can follow the state.
  task automatic push_tick(input tick_t t);
    result_t unused;
    advance_sequencer(planned_seq, t, unused);
    ticks_to_send.push_back(t);
    ticks_planned++;
  endtask

  function automatic tick_t uniform_tick(input logic [2:0] node_st, input logic [5:0] heard,
                                         input fan_e fan, input logic [2:0] req);
    tick_t t;
    t.cc_state        = node_st;
    t.fsm_state       = node_st;
    t.rsm_state       = node_st;
    t.dim_state       = node_st;
    t.afc_state       = node_st;
    t.tm_state        = node_st;
    t.heard_mask      = heard;
    t.fan1_status     = fan;
    t.fan2_status     = fan;
    t.fan3_status     = fan;
    t.requested_state = req;
    return t;
  endfunction

  // Mostly nodes agree with the system state, so the guards can actually pass.
  function automatic logic [2:0] pick_node(input logic [2:0] cur);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 92) return cur;
    if (r < 94) return ST_ERROR;
    return 3'($urandom_range(7));
  endfunction

  // A tick that pushes the sequencer along its normal path, with random detail.
  task automatic plan_coherent_tick(output tick_t t);
    logic [2:0] cur, nat_req;
    fan_e       nat_fan;
    cur = planned_seq.sys;
    case (cur)
      ST_GLV_ON: begin
        nat_req = ST_HV_EN;
        nat_fan = FAN_LOW;
      end
      ST_HV_EN: begin
        nat_req = $urandom_range(1) ? ST_RTD : ST_GLV_ON;
        nat_fan = FAN_FULL;
      end
      ST_RTD: begin
        nat_req = ST_HV_EN;
        nat_fan = FAN_LOW;
      end
      default: begin
        nat_req = ST_GLV_ON;
        nat_fan = FAN_OFF;
      end
    endcase
    t.cc_state  = pick_node(cur);
    t.fsm_state = pick_node(cur);
    t.rsm_state = pick_node(cur);
    t.dim_state = pick_node(cur);
    t.afc_state = pick_node(cur);
    t.tm_state  = pick_node(cur);
    t.requested_state = ($urandom_range(99) < 75) ? nat_req : 3'($urandom_range(7));
    if ($urandom_range(99) < 75) begin
      t.fan1_status = nat_fan;
      t.fan2_status = nat_fan;
      t.fan3_status = nat_fan;
    end else begin
      t.fan1_status = 2'($urandom_range(3));
      t.fan2_status = 2'($urandom_range(3));
      t.fan3_status = 2'($urandom_range(3));
    end
    // Occasional stretches where some nodes fall silent, to reach the timeouts.
    if (mute_left == 0 && $urandom_range(99) < 4) begin
      mute_mask = 6'($urandom_range(1, 63));
      mute_left = $urandom_range(1, 16);
    end
    t.heard_mask = 6'h3F;
    if (mute_left != 0) begin
      t.heard_mask = ~mute_mask;
      mute_left--;
    end
    if ($urandom_range(99) < 5) t.heard_mask = t.heard_mask & 6'($urandom_range(63));
  endtask

  // Hold until every queued tick has produced its checked result.
  task automatic wait_drained();
    while (ticks_to_send.size() != 0 || results_seen != ticks_planned)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input cfg_reg_e idx, input logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == REG_HEARTBEAT_LIMIT) begin
      planned_seq.hb_limit = val;
      tracked_seq.hb_limit = val;
    end else begin
      planned_seq.mm_limit = val;
      tracked_seq.mm_limit = val;
    end
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Tick driver: offers the next queued tick once the current beat has gone.
  always @(negedge clk_i) begin
    if (!tick_ch.valid || in_taken) begin
      if (ticks_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        tick_ch.valid   <= 1'b1;
        tick_ch.payload <= ticks_to_send.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure and the long hold-off.
  always @(negedge clk_i) begin
    result_ch.ready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor: predicts on accepted ticks and checks accepted results.
  always @(posedge clk_i) begin
    result_t predicted;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= tick_ch.valid && tick_ch.ready;
      if (tick_ch.valid && tick_ch.ready) begin
        advance_sequencer(tracked_seq, tick_ch.payload, predicted);
        expected_results.push_back(predicted);
        ticks_taken++;
      end
      if (result_ch.valid && result_ch.ready) check_result(result_ch.payload);
    end
  end

  // Stimulus and run control.
  initial begin
    tick_t       t;
    logic [63:0] raw;
    tick_ch.valid   = 1'b0;
    tick_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.payload  = '{index: REG_HEARTBEAT_LIMIT, data: '0};
    planned_seq     = '0;
    planned_seq.sys      = ST_GLV_ON;
    planned_seq.goal     = ST_GLV_ON;
    planned_seq.hb_limit = HEARTBEAT_LIMIT_RST;
    planned_seq.mm_limit = MISMATCH_LIMIT_RST;
    tracked_seq     = planned_seq;
    foreach (state_hits[i]) state_hits[i] = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed walk through the main transitions at the reset limits.
    push_tick(uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, ST_HV_EN));
    push_tick(uniform_tick(ST_HV_EN, 6'h3F, FAN_FULL, ST_RTD));
    push_tick(uniform_tick(ST_RTD, 6'h3F, FAN_LOW, ST_HV_EN));
    push_tick(uniform_tick(ST_HV_EN, 6'h3F, FAN_OFF, ST_GLV_ON));
    push_tick(uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, 3'd7));
    push_tick(uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, 3'd6));
    push_tick(uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, ST_RTD));
    push_tick(uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, ST_HV_EN));
    // A fan fault while high voltage is enabled.
    t = uniform_tick(ST_HV_EN, 6'h3F, FAN_FULL, ST_HV_EN);
    t.fan2_status = FAN_ERR;
    push_tick(t);
    push_tick(uniform_tick(ST_ERROR, 6'h3F, FAN_OFF, ST_GLV_ON));
    // A node error is ignored while clearing.
    t = uniform_tick(ST_CLEAR, 6'h3F, FAN_OFF, ST_GLV_ON);
    t.cc_state = ST_ERROR;
    push_tick(t);
    push_tick(uniform_tick(ST_CLEAR, 6'h3F, FAN_OFF, ST_GLV_ON));
    // Out-of-range node states on the monitor-only nodes and the driver interface.
    t = uniform_tick(ST_GLV_ON, 6'h3F, FAN_LOW, ST_HV_EN);
    t.rsm_state = 3'd6;
    t.tm_state  = 3'd7;
    t.dim_state = 3'd7;
    push_tick(t);
    t = uniform_tick(ST_HV_EN, 6'h3F, FAN_FULL, ST_RTD);
    t.afc_state = 3'd6;
    push_tick(t);
    t = uniform_tick(ST_HV_EN, 6'h3F, FAN_LOW, ST_HV_EN);
    t.dim_state = ST_ERROR;
    push_tick(t);
    push_tick(uniform_tick(ST_ERROR, 6'h3F, FAN_ERR, ST_GLV_ON));
    push_tick(uniform_tick(ST_ERROR, 6'h3F, FAN_OFF, ST_HV_EN));
    push_tick(uniform_tick(3'd7, 6'h3F, FAN_ERR, 3'd7));
    push_tick(uniform_tick(ST_UNKNOWN, 6'h00, FAN_OFF, ST_UNKNOWN));

    // Zero limits: one silent tick times every node out.
    wait_drained();
    write_limit(REG_HEARTBEAT_LIMIT, '0);
    write_limit(REG_MISMATCH_LIMIT, '0);
    push_tick(uniform_tick(ST_ERROR, 6'h00, FAN_OFF, ST_GLV_ON));
    push_tick(uniform_tick(ST_ERROR, 6'h00, FAN_OFF, ST_GLV_ON));
    push_tick(uniform_tick(ST_ERROR, 6'h3F, FAN_OFF, ST_GLV_ON));
    push_tick(uniform_tick(ST_ERROR, 6'h3F, FAN_OFF, ST_GLV_ON));
    push_tick(uniform_tick(ST_CLEAR, 6'h3F, FAN_OFF, ST_GLV_ON));

    // Random phases, each under its own pair of limits.
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_limit(REG_HEARTBEAT_LIMIT, 16'd3);
          write_limit(REG_MISMATCH_LIMIT, 16'd2);
        end
        1: begin
          write_limit(REG_HEARTBEAT_LIMIT, '0);
          write_limit(REG_MISMATCH_LIMIT, '0);
        end
        2: begin
          write_limit(REG_HEARTBEAT_LIMIT, '1);
          write_limit(REG_MISMATCH_LIMIT, '1);
        end
        3: begin
          write_limit(REG_HEARTBEAT_LIMIT, 16'($urandom_range(1, 24)));
          write_limit(REG_MISMATCH_LIMIT, 16'($urandom_range(1, 24)));
        end
        default: begin
          write_limit(REG_HEARTBEAT_LIMIT, HEARTBEAT_LIMIT_RST);
          write_limit(REG_MISMATCH_LIMIT, 16'($urandom_range(0, 16)));
        end
      endcase
      src_idle_pct  = (p < 2) ? 16 : (p < 4) ? 45 : 0;
      sink_idle_pct = (p < 2) ? 45 : (p < 4) ? 16 : 0;
      for (int i = 0; i < 300; i++) begin
        // Once, starve the result side so the block backs up onto its input.
        if (p == 2 && i == 60) begin
          fork
            begin
              @(negedge clk_i) rx_hold <= 1'b1;
              repeat (150) @(negedge clk_i);
              rx_hold <= 1'b0;
            end
          join_none
        end
        if ($urandom_range(99) < 15) begin
          raw = {$urandom, $urandom};
          t   = raw[$bits(tick_t)-1:0];
        end else begin
          plan_coherent_tick(t);
        end
        push_tick(t);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d results over seven limit settings.",
             ticks_taken, results_seen);
    $display("Results in hv_en %0d, rtd %0d, error %0d, clearing %0d; %0d mismatches.",
             state_hits[ST_HV_EN], state_hits[ST_RTD], state_hits[ST_ERROR],
             state_hits[ST_CLEAR], mismatches);
    if (mismatches == 0) begin
      $display("PASS vehicle_safety_state_sequencer");
    end else begin
      $display("FAIL vehicle_safety_state_sequencer");
    end
    $finish;
  end

  // Watchdog in case the handshakes hang.
  initial begin
    #2_000_000;
    $display("Timed out with %0d ticks queued and %0d results outstanding.",
             ticks_to_send.size(), expected_results.size());
    $display("FAIL vehicle_safety_state_sequencer");
    $finish;
  end

endmodule
